[rtl/derenc_pkg.sv]
`default_nettype none

package derenc_pkg;

  localparam int unsigned ByteCount = 10;

  localparam logic [7:0] TAG_INT   = 8'h02;
  localparam logic [7:0] TAG_SEQ   = 8'h30;
  localparam logic [7:0] LONG_FORM = 8'h80;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] SHORT_MAX = 8'd127;

  localparam logic ACTION_INT = 1'b0;
  localparam logic ACTION_SEQ = 1'b1;

  // One encoded item: two leading bytes, then up to eight body bytes taken
  // from the top of body, and the total number of bytes.
  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  len_byte;
    logic [63:0] body;
    logic [3:0]  count;
  } enc_t;

endpackage

`default_nettype wire

[rtl/derenc_build.sv]
`default_nettype none

module derenc_build
  import derenc_pkg::*;
#(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  wire logic        action,
  input  wire logic [63:0] int_value,
  input  wire logic [31:0] content_length,
  output enc_t             enc
);

  localparam int unsigned CapBits = 8 * LENGTH_BYTES;
  localparam logic [63:0] LenCap  = (64'd1 << CapBits) - 64'd1;

  logic [7:1]  redundant;
  logic [3:0]  n_int;
  logic [3:0]  n_len;
  logic [63:0] len64;

  // A top byte is redundant when it only repeats the sign of the byte below.
  always_comb begin
    for (int k = 1; k < 8; k++) begin
      redundant[k] = (int_value[8*k +: 8] == 8'h00 && !int_value[8*k-1]) ||
                     (int_value[8*k +: 8] == BYTE_ONES && int_value[8*k-1]);
    end
  end

  always_comb begin
    logic stop;
    stop  = 1'b0;
    n_int = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      if (!stop && redundant[k]) begin
        n_int = 4'(k);
      end else begin
        stop = 1'b1;
      end
    end
  end

  always_comb begin
    len64 = {32'd0, content_length};
    if (len64 > LenCap) begin
      len64 = LenCap;
    end
    n_len = 4'd1;
    for (int k = 1; k < 8; k++) begin
      if (len64[8*k +: 8] != 8'h00) begin
        n_len = 4'(k + 1);
      end
    end
  end

  always_comb begin
    enc = '0;
    case (action)
      ACTION_INT: begin
        enc.tag      = TAG_INT;
        enc.len_byte = {4'd0, n_int};
        enc.body     = int_value << {4'd8 - n_int, 3'b000};
        enc.count    = 4'd2 + n_int;
      end
      ACTION_SEQ: begin
        enc.tag = TAG_SEQ;
        if (len64 <= {56'd0, SHORT_MAX}) begin
          enc.len_byte = len64[7:0];
          enc.count    = 4'd2;
        end else begin
          enc.len_byte = LONG_FORM | {4'd0, n_len};
          enc.body     = len64 << {4'd8 - n_len, 3'b000};
          enc.count    = 4'd2 + n_len;
        end
      end
      default: begin
        enc = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/der_integer_and_header_encoder.sv]
`default_nettype none

// DER encoder for INTEGER values and SEQUENCE headers. An item is taken when
// start is high and busy is low; it is held in an input register, encoded by
// combinational logic and moved into a byte shifter that puts out one byte per
// cycle, marked by valid, with last on the final byte. An item gives 2 to 10
// bytes; the byte shifter sets the rate. The next item may be accepted while
// the current one is still being sent, and if it is taken before the final
// byte of the current one its bytes follow with no gap. The receiver cannot
// stall: every byte is on out_byte for exactly one cycle.
module der_integer_and_header_encoder
  import derenc_pkg::*;
#(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [63:0] int_value,
  input  wire logic [31:0] content_length,
  output logic             valid,
  output logic [7:0]       out_byte,
  output logic             last
);

  logic        in_full;
  logic        in_action;
  logic [63:0] in_int_value;
  logic [31:0] in_content_length;
  enc_t        enc;

  logic [7:0]  ser_bytes [ByteCount];
  logic [3:0]  ser_left;

  logic        load;
  logic        accept;

  derenc_build #(
    .LENGTH_BYTES(LENGTH_BYTES)
  ) u_build (
    .action        (in_action),
    .int_value     (in_int_value),
    .content_length(in_content_length),
    .enc           (enc)
  );

  // The shifter takes the held item when it is empty or on its final byte.
  assign load   = in_full && (ser_left <= 4'd1);
  assign busy   = in_full && !load;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_action         <= action;
      in_int_value      <= int_value;
      in_content_length <= content_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_left <= 4'd0;
    end else if (load) begin
      ser_left <= enc.count;
    end else if (ser_left != 4'd0) begin
      ser_left <= ser_left - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_bytes[0] <= enc.tag;
      ser_bytes[1] <= enc.len_byte;
      for (int i = 0; i < 8; i++) begin
        ser_bytes[i+2] <= enc.body[63-8*i -: 8];
      end
    end else begin
      for (int i = 0; i < ByteCount - 1; i++) begin
        ser_bytes[i] <= ser_bytes[i+1];
      end
      ser_bytes[ByteCount-1] <= 8'h00;
    end
  end

  assign valid    = (ser_left != 4'd0);
  assign out_byte = ser_bytes[0];
  assign last     = (ser_left == 4'd1);

endmodule

`default_nettype wire
